// ----- rtl/core/dtpy_pkg.sv -----
// shared types, constants and arctangent table for direction_to_pitch_yaw
package dtpy_pkg;

    localparam int COORD_BITS      = 32;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 16;
    localparam int MAX_STEPS       = 32;

    // coordinate differences
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int POS_BITS  = $clog2(DIFF_BITS);

    // normalized magnitudes lie in [2^28, 2^29)
    localparam int NORM_MSB  = 28;
    localparam int NORM_BITS = NORM_MSB + 1;

    // square root of the horizontal length
    localparam int SQ_IN_BITS = 2 * NORM_BITS + 2;
    localparam int SQ_STEPS   = SQ_IN_BITS / 2;

    // cordic datapath
    localparam int XY_BITS = NORM_BITS + 5;
    localparam int Z_BITS  = 36;

    // degree conversion
    localparam int OUT_BITS   = 9 + ANGLE_FRAC_BITS;
    localparam int DEG_SCALE  = 180 << ANGLE_FRAC_BITS;
    localparam int SCALE_BITS = $clog2(DEG_SCALE + 1);
    localparam int QUO_BITS   = OUT_BITS + 1;
    localparam int NUM_BITS   = Z_BITS + SCALE_BITS + 1;
    localparam longint PI_Q30 = 64'd3373259426;

    // |z| stays below 4.9 rad, so the rounded numerator stays below 2^47;
    // its top 32 bits times floor(2^48 / pi_q30) give the quotient or one less
    localparam int     NUM_HI_LSB  = 15;
    localparam int     NUM_HI_BITS = 32;
    localparam int     RECIP_SHIFT = 48;
    localparam int     RECIP_BITS  = 17;
    localparam longint RECIP       = (64'sd1 <<< RECIP_SHIFT) / PI_Q30;
    localparam int     DEG_STAGES  = 5;

    localparam logic [OUT_BITS-1:0] FULL_TURN = OUT_BITS'(360 << ANGLE_FRAC_BITS);
    localparam logic [OUT_BITS-1:0] ANGLE_270 = OUT_BITS'(270 << ANGLE_FRAC_BITS);
    localparam logic [OUT_BITS-1:0] ANGLE_90  = OUT_BITS'(90 << ANGLE_FRAC_BITS);

    // atan(2^-i) in radians, Q30
    localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd1
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] src_x;
        logic signed [COORD_BITS-1:0] src_y;
        logic signed [COORD_BITS-1:0] src_z;
        logic signed [COORD_BITS-1:0] dst_x;
        logic signed [COORD_BITS-1:0] dst_y;
        logic signed [COORD_BITS-1:0] dst_z;
    } t_in_word;

    typedef struct packed {
        logic [OUT_BITS-1:0] pitch_deg;
        logic [OUT_BITS-1:0] yaw_deg;
    } t_out_word;

    function automatic int steps_used(int steps);
        return (steps < MAX_STEPS) ? steps : MAX_STEPS;
    endfunction

    function automatic int latency(int steps);
        return 5 + SQ_STEPS + 1 + steps_used(steps) + DEG_STAGES + 1;
    endfunction

endpackage

// ----- rtl/core/direction_to_pitch_yaw.sv -----
// top level: pitch and yaw of the vector between two points
// throughput: one word per cycle; busy is always low and every word is taken
// the receiver cannot stall: each result shows on o_out for one cycle with o_strobe
// reset: synchronous, active low; clears the valid bits of every stage, data is not reset
module direction_to_pitch_yaw #(
    parameter int CORDIC_STEPS = dtpy_pkg::CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  dtpy_pkg::t_in_word  i_in,
    output logic                o_strobe,
    output dtpy_pkg::t_out_word o_out
);

    localparam int CB  = dtpy_pkg::COORD_BITS;
    localparam int DW  = dtpy_pkg::DIFF_BITS;
    localparam int PW  = dtpy_pkg::POS_BITS;
    localparam int NB  = dtpy_pkg::NORM_BITS;
    localparam int SW  = dtpy_pkg::SQ_IN_BITS;
    localparam int SQ  = dtpy_pkg::SQ_STEPS;
    localparam int XW  = dtpy_pkg::XY_BITS;
    localparam int OW  = dtpy_pkg::OUT_BITS;
    localparam int PRE = 5 + SQ;   // stages ahead of the cordics
    localparam int DLY = SQ + 3;   // taps of the side line

    // yaw operands, the pitch z operand and flags riding along with the square root
    typedef struct packed {
        logic signed [NB:0] hx;
        logic signed [NB:0] hy;
        logic signed [NB:0] pz;
        logic               vert;
        logic               dzpos;
    } t_side;

    // magnitude of a signed difference, 2^32 still fits
    function automatic logic [DW-1:0] mag_of(logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // position of the leading one
    function automatic logic [PW-1:0] lead_pos(logic [DW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < DW; i++) begin
            if (v[i]) begin
                p = PW'(i);
            end
        end
        return p;
    endfunction

    // scale by a power of two so the leading one of the group lands on NORM_MSB
    function automatic logic [NB-1:0] norm_mag(logic [DW-1:0] m, logic [PW-1:0] pos);
        logic [DW+NB-1:0] w;
        w = {{NB{1'b0}}, m};
        if (int'(pos) > dtpy_pkg::NORM_MSB) begin
            w = w >> (int'(pos) - dtpy_pkg::NORM_MSB);
        end else begin
            w = w << (dtpy_pkg::NORM_MSB - int'(pos));
        end
        return w[NB-1:0];
    endfunction

    function automatic logic signed [NB:0] with_sign(logic [NB-1:0] m, logic neg);
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // ---------------------------------------------------------------------
    // valid chain up to the cordics
    // ---------------------------------------------------------------------
    logic r_vld [1:PRE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= PRE; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[1] <= start & ~busy;
            for (int i = 2; i <= PRE; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: differences, magnitudes and the vertical case
    // ---------------------------------------------------------------------
    logic signed [DW-1:0] n_dx, n_dy, n_dz;
    logic [DW-1:0]        r1_mx, r1_my, r1_mz;
    logic                 r1_sx, r1_sy, r1_sz, r1_vert, r1_dzpos;

    assign n_dx = {i_in.dst_x[CB-1], i_in.dst_x} - {i_in.src_x[CB-1], i_in.src_x};
    assign n_dy = {i_in.dst_y[CB-1], i_in.dst_y} - {i_in.src_y[CB-1], i_in.src_y};
    assign n_dz = {i_in.dst_z[CB-1], i_in.dst_z} - {i_in.src_z[CB-1], i_in.src_z};

    always_ff @(posedge i_clk) begin
        r1_mx    <= mag_of(n_dx);
        r1_my    <= mag_of(n_dy);
        r1_mz    <= mag_of(n_dz);
        r1_sx    <= n_dx[DW-1];
        r1_sy    <= n_dy[DW-1];
        r1_sz    <= n_dz[DW-1];
        r1_vert  <= (n_dx == '0) && (n_dy == '0);
        r1_dzpos <= (n_dz > 0);
    end

    // ---------------------------------------------------------------------
    // stage 2: leading one of the horizontal pair and of all three
    // ---------------------------------------------------------------------
    logic [DW-1:0] r2_mx, r2_my, r2_mz;
    logic          r2_sx, r2_sy, r2_sz, r2_vert, r2_dzpos;
    logic [PW-1:0] r2_hpos, r2_ppos;

    always_ff @(posedge i_clk) begin
        r2_mx    <= r1_mx;
        r2_my    <= r1_my;
        r2_mz    <= r1_mz;
        r2_sx    <= r1_sx;
        r2_sy    <= r1_sy;
        r2_sz    <= r1_sz;
        r2_vert  <= r1_vert;
        r2_dzpos <= r1_dzpos;
        r2_hpos  <= lead_pos(r1_mx | r1_my);
        r2_ppos  <= lead_pos(r1_mx | r1_my | r1_mz);
    end

    // ---------------------------------------------------------------------
    // stage 3: normalize, truncating magnitudes, then restore signs
    // ---------------------------------------------------------------------
    t_side         r_side [DLY];
    logic [NB-1:0] r3_px, r3_py;

    always_ff @(posedge i_clk) begin
        r_side[0].hx    <= with_sign(norm_mag(r2_mx, r2_hpos), r2_sx);
        r_side[0].hy    <= with_sign(norm_mag(r2_my, r2_hpos), r2_sy);
        r_side[0].pz    <= with_sign(norm_mag(r2_mz, r2_ppos), r2_sz);
        r_side[0].vert  <= r2_vert;
        r_side[0].dzpos <= r2_dzpos;
        r3_px           <= norm_mag(r2_mx, r2_ppos);
        r3_py           <= norm_mag(r2_my, r2_ppos);
        for (int i = 1; i < DLY; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // ---------------------------------------------------------------------
    // stages 4 and 5: squares and their sum
    // ---------------------------------------------------------------------
    logic [2*NB-1:0] r4_xx, r4_yy;
    logic [SW-1:0]   r_sq_a [SQ+1];
    logic [SW-1:0]   r_sq_r [SQ+1];

    always_ff @(posedge i_clk) begin
        r4_xx     <= r3_px * r3_px;
        r4_yy     <= r3_py * r3_py;
        r_sq_a[0] <= SW'(r4_xx) + SW'(r4_yy);
        r_sq_r[0] <= '0;
    end

    // ---------------------------------------------------------------------
    // integer square root, one result bit per stage
    // ---------------------------------------------------------------------
    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ - 1 - j));
        logic [SW-1:0] n_trial;

        assign n_trial = r_sq_r[j] + BIT;

        always_ff @(posedge i_clk) begin
            if (r_sq_a[j] >= n_trial) begin
                r_sq_a[j+1] <= r_sq_a[j] - n_trial;
                r_sq_r[j+1] <= (r_sq_r[j] >> 1) + BIT;
            end else begin
                r_sq_a[j+1] <= r_sq_a[j];
                r_sq_r[j+1] <= r_sq_r[j] >> 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // cordics: yaw from (hx, hy), pitch from (r, -pz)
    // ---------------------------------------------------------------------
    t_side                side_q;
    logic signed [XW-1:0] n_yaw_x, n_yaw_y, n_pit_x, n_pit_y;

    assign side_q  = r_side[DLY-1];
    assign n_yaw_x = {{(XW-NB-1){side_q.hx[NB]}}, side_q.hx};
    assign n_yaw_y = {{(XW-NB-1){side_q.hy[NB]}}, side_q.hy};
    assign n_pit_x = $signed({{(XW-NB-1){1'b0}}, r_sq_r[SQ][NB:0]});
    assign n_pit_y = -$signed({{(XW-NB-1){side_q.pz[NB]}}, side_q.pz});

    logic                              yaw_z_vld, pit_z_vld;
    logic signed [dtpy_pkg::Z_BITS-1:0] yaw_z, pit_z;
    logic                              yaw_z_vert, pit_z_dzpos;

    dtpy_cordic #(
        .STEPS    (CORDIC_STEPS),
        .TAG_BITS (1)
    ) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[PRE]),
        .i_x     (n_yaw_x),
        .i_y     (n_yaw_y),
        .i_tag   (side_q.vert),
        .o_vld   (yaw_z_vld),
        .o_z     (yaw_z),
        .o_tag   (yaw_z_vert)
    );

    dtpy_cordic #(
        .STEPS    (CORDIC_STEPS),
        .TAG_BITS (1)
    ) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[PRE]),
        .i_x     (n_pit_x),
        .i_y     (n_pit_y),
        .i_tag   (side_q.dzpos),
        .o_vld   (pit_z_vld),
        .o_z     (pit_z),
        .o_tag   (pit_z_dzpos)
    );

    // ---------------------------------------------------------------------
    // degree conversion
    // ---------------------------------------------------------------------
    logic          yaw_d_vld, pit_d_vld, yaw_d_vert, pit_d_dzpos;
    logic [OW-1:0] yaw_d, pit_d;

    dtpy_to_deg #(
        .TAG_BITS (1)
    ) u_deg_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (yaw_z_vld),
        .i_z     (yaw_z),
        .i_tag   (yaw_z_vert),
        .o_vld   (yaw_d_vld),
        .o_deg   (yaw_d),
        .o_tag   (yaw_d_vert)
    );

    dtpy_to_deg #(
        .TAG_BITS (1)
    ) u_deg_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (pit_z_vld),
        .i_z     (pit_z),
        .i_tag   (pit_z_dzpos),
        .o_vld   (pit_d_vld),
        .o_deg   (pit_d),
        .o_tag   (pit_d_dzpos)
    );

    // ---------------------------------------------------------------------
    // output word, vertical vectors replaced by fixed angles
    // ---------------------------------------------------------------------
    logic                r_strobe;
    dtpy_pkg::t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= yaw_d_vld & pit_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (yaw_d_vert) begin
            r_out.pitch_deg <= pit_d_dzpos ? dtpy_pkg::ANGLE_270 : dtpy_pkg::ANGLE_90;
            r_out.yaw_deg   <= '0;
        end else begin
            r_out.pitch_deg <= pit_d;
            r_out.yaw_deg   <= yaw_d;
        end
    end

    // fully pipelined, never holds off a start
    assign busy     = 1'b0;
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

// ----- rtl/core/dtpy_cordic.sv -----
// pipelined vectoring cordic, one stage per iteration
module dtpy_cordic #(
    parameter int STEPS    = dtpy_pkg::CORDIC_STEPS,
    parameter int TAG_BITS = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic signed [dtpy_pkg::XY_BITS-1:0]   i_x,
    input  logic signed [dtpy_pkg::XY_BITS-1:0]   i_y,
    input  logic [TAG_BITS-1:0]                   i_tag,
    output logic                                  o_vld,
    output logic signed [dtpy_pkg::Z_BITS-1:0]    o_z,
    output logic [TAG_BITS-1:0]                   o_tag
);

    localparam int NS = dtpy_pkg::steps_used(STEPS);
    localparam int XW = dtpy_pkg::XY_BITS;
    localparam int ZW = dtpy_pkg::Z_BITS;
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'({dtpy_pkg::ATAN_TAB[0], 2'b00});

    logic                 r_vld [NS+1];
    logic signed [XW-1:0] r_x   [NS+1];
    logic signed [XW-1:0] r_y   [NS+1];
    logic signed [ZW-1:0] r_z   [NS+1];
    logic [TAG_BITS-1:0]  r_tag [NS+1];

    // turn by pi when the vector points into the left half plane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_z[0] <= (i_y >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        localparam logic signed [ZW-1:0] ANG = ZW'(dtpy_pkg::ATAN_TAB[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[i+1] <= r_tag[i];
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ANG;
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ANG;
            end
        end
    end

    assign o_vld = r_vld[NS];
    assign o_z   = r_z[NS];
    assign o_tag = r_tag[NS];

endmodule

// ----- rtl/core/dtpy_to_deg.sv -----
// radians q30 to wrapped degrees, reciprocal multiply by 1/pi with one correction step
module dtpy_to_deg #(
    parameter int TAG_BITS = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [dtpy_pkg::Z_BITS-1:0]  i_z,
    input  logic [TAG_BITS-1:0]                 i_tag,
    output logic                                o_vld,
    output logic [dtpy_pkg::OUT_BITS-1:0]       o_deg,
    output logic [TAG_BITS-1:0]                 o_tag
);

    localparam int ZW  = dtpy_pkg::Z_BITS;
    localparam int NW  = dtpy_pkg::NUM_BITS;
    localparam int QW  = dtpy_pkg::QUO_BITS;
    localparam int OW  = dtpy_pkg::OUT_BITS;
    localparam int DV  = dtpy_pkg::DEG_STAGES;
    localparam int HL  = dtpy_pkg::NUM_HI_LSB;
    localparam int HW  = dtpy_pkg::NUM_HI_BITS;
    localparam int RW  = dtpy_pkg::RECIP_BITS;
    localparam int PRW = HW + RW;
    localparam int QSH = dtpy_pkg::RECIP_SHIFT - dtpy_pkg::NUM_HI_LSB;
    localparam logic [NW-1:0]  SCALE   = NW'(dtpy_pkg::DEG_SCALE);
    localparam logic [NW-1:0]  HALF    = NW'(dtpy_pkg::PI_Q30 / 2);
    localparam logic [NW-1:0]  DIVISOR = NW'(dtpy_pkg::PI_Q30);
    localparam logic [PRW-1:0] RECIP   = PRW'(dtpy_pkg::RECIP);

    logic [ZW-1:0]       w_mag;
    logic [QW-1:0]       w_q0;
    logic [NW-1:0]       w_rem;
    logic [DV-1:0]       r_vld;
    logic [NW-1:0]       r0_num, r1_num, r2_num;
    logic                r0_neg, r1_neg, r2_neg, r3_neg;
    logic [TAG_BITS-1:0] r0_tag, r1_tag, r2_tag, r3_tag;
    logic [PRW-1:0]      r1_prod;
    logic [QW-1:0]       r2_q0, r3_quo;
    logic [NW-1:0]       r2_qd;
    logic [OW-1:0]       r_deg;
    logic [TAG_BITS-1:0] r_out_tag;

    assign w_mag = i_z[ZW-1] ? ZW'(-i_z) : ZW'(i_z);
    assign w_q0  = QW'(r1_prod >> QSH);
    assign w_rem = r2_num - r2_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DV-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // numerator with half the divisor added for rounding
        r0_neg  <= i_z[ZW-1];
        r0_num  <= NW'(w_mag) * SCALE + HALF;
        r0_tag  <= i_tag;
        // quotient estimate from the top bits, never above the true quotient
        r1_prod <= PRW'(r0_num[HL+HW-1:HL]) * RECIP;
        r1_num  <= r0_num;
        r1_neg  <= r0_neg;
        r1_tag  <= r0_tag;
        // estimate times the divisor
        r2_q0   <= w_q0;
        r2_qd   <= NW'(w_q0) * DIVISOR;
        r2_num  <= r1_num;
        r2_neg  <= r1_neg;
        r2_tag  <= r1_tag;
        // estimate is at most one short
        r3_quo  <= (w_rem >= DIVISOR) ? r2_q0 + QW'(1) : r2_q0;
        r3_neg  <= r2_neg;
        r3_tag  <= r2_tag;
    end

    // negative angles wrap into [0, 360)
    always_ff @(posedge i_clk) begin
        r_out_tag <= r3_tag;
        if (r3_neg && (r3_quo != '0)) begin
            r_deg <= dtpy_pkg::FULL_TURN - r3_quo[OW-1:0];
        end else begin
            r_deg <= r3_quo[OW-1:0];
        end
    end

    assign o_vld = r_vld[DV-1];
    assign o_deg = r_deg;
    assign o_tag = r_out_tag;

endmodule

// ----- rtl/core/dtpy_checker.sv -----
// port checker for direction_to_pitch_yaw and its bind
module dtpy_checker #(
    parameter int CORDIC_STEPS = dtpy_pkg::CORDIC_STEPS
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input dtpy_pkg::t_in_word  i_in,
    input logic                o_strobe,
    input dtpy_pkg::t_out_word o_out
);

    localparam int LAT = dtpy_pkg::latency(CORDIC_STEPS);

    // every accepted word comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted word did not produce a result");

    // no result without a word accepted the same distance back
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without a matching word");

    // angles stay wrapped
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out.pitch_deg < dtpy_pkg::FULL_TURN) &&
                     (o_out.yaw_deg < dtpy_pkg::FULL_TURN))
        else $error("angle out of range");

    // a vertical vector gives zero yaw and pitch of 90 or 270
    a_vertical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past((i_in.dst_x == i_in.src_x) && (i_in.dst_y == i_in.src_y), LAT))
        |-> (o_out.yaw_deg == '0) &&
            ((o_out.pitch_deg == dtpy_pkg::ANGLE_90) ||
             (o_out.pitch_deg == dtpy_pkg::ANGLE_270)))
        else $error("vertical vector gave wrong angles");

endmodule

bind direction_to_pitch_yaw dtpy_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_dtpy_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_strobe (o_strobe),
    .o_out    (o_out)
);

// ----- dv/tb.sv -----
// testbench for direction_to_pitch_yaw: random and directed point pairs checked against a predictor
`timescale 1ns / 100ps

// holds the expected angles of accepted words and checks results against them
class angle_scoreboard;
    localparam longint PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint PI_RAD = (PI_Q60 + (64'sd1 <<< 29)) >>> 30;
    localparam longint TURN   = 64'sd360 <<< dtpy_pkg::ANGLE_FRAC_BITS;
    localparam int     STEPS  = (dtpy_pkg::CORDIC_STEPS < 32) ? dtpy_pkg::CORDIC_STEPS : 32;

    dtpy_pkg::t_out_word pending_angles[$];
    longint              atan_q30[32];
    int                  errors;
    int                  checked;

    function new();
        longint s, term;
        int     e;
        errors  = 0;
        checked = 0;
        atan_q30[0] = (PI_Q60 + (64'sd1 <<< 31)) >>> 32;
        for (int i = 1; i < 32; i++) begin
            s = 0;
            for (int k = 0; k < 32; k++) begin
                e = i * (2 * k + 1);
                if (e > 62) break;
                term = longint'((64'd1 << (62 - e)) / longint'(unsigned'(2 * k + 1)));
                s = (k & 1) ? s - term : s + term;
            end
            atan_q30[i] = (s + (64'sd1 <<< 31)) >>> 32;
        end
    endfunction

    static function longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // common power-of-two scale so the largest magnitude sits in [2^28, 2^29)
    function void scale_common(inout longint v[3], input int n);
        longint m[3];
        longint top;
        top = 0;
        for (int i = 0; i < n; i++) begin
            m[i] = magnitude(v[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) return;
        while (top >= (64'sd1 <<< 29)) begin
            top = top >>> 1;
            for (int i = 0; i < n; i++) m[i] = m[i] >>> 1;
        end
        while (top < (64'sd1 <<< 28)) begin
            top = top <<< 1;
            for (int i = 0; i < n; i++) m[i] = m[i] <<< 1;
        end
        for (int i = 0; i < n; i++) v[i] = (v[i] < 0) ? -m[i] : m[i];
    endfunction

    static function longint floor_sqrt(longint a);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > a) b = b >>> 2;
        while (b != 0) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle in radians q30
    function longint vector_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 4 * atan_q30[0] : -(4 * atan_q30[0]);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + atan_q30[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_q30[i];
            end
        end
        return z;
    endfunction

    function logic [dtpy_pkg::OUT_BITS-1:0] radians_to_degrees(longint z);
        longint d;
        d = (magnitude(z) * 180 * (64'sd1 <<< dtpy_pkg::ANGLE_FRAC_BITS) + PI_RAD / 2) / PI_RAD;
        if (z < 0) d = -d;
        while (d < 0) d = d + TURN;
        while (d >= TURN) d = d - TURN;
        return d[dtpy_pkg::OUT_BITS-1:0];
    endfunction

    function dtpy_pkg::t_out_word predict_angles(dtpy_pkg::t_in_word w);
        dtpy_pkg::t_out_word r;
        longint dx, dy, dz, hz, ax, ay;
        longint h[3];
        longint p[3];
        dx = longint'(w.dst_x) - longint'(w.src_x);
        dy = longint'(w.dst_y) - longint'(w.src_y);
        dz = longint'(w.dst_z) - longint'(w.src_z);
        // straight up or down: no heading
        if (dx == 0 && dy == 0) begin
            r.yaw_deg   = '0;
            r.pitch_deg = (dz > 0) ? dtpy_pkg::OUT_BITS'(270 << dtpy_pkg::ANGLE_FRAC_BITS)
                                   : dtpy_pkg::OUT_BITS'(90 << dtpy_pkg::ANGLE_FRAC_BITS);
            return r;
        end
        h[0] = dx; h[1] = dy; h[2] = 0;
        scale_common(h, 2);
        r.yaw_deg = radians_to_degrees(vector_angle(h[0], h[1]));
        p[0] = dx; p[1] = dy; p[2] = dz;
        scale_common(p, 3);
        ax = magnitude(p[0]);
        ay = magnitude(p[1]);
        hz = floor_sqrt(ax * ax + ay * ay);
        r.pitch_deg = radians_to_degrees(vector_angle(hz, -p[2]));
        return r;
    endfunction

    function void note_word(dtpy_pkg::t_in_word w);
        pending_angles.push_back(predict_angles(w));
    endfunction

    function void check_result(dtpy_pkg::t_out_word got);
        dtpy_pkg::t_out_word want;
        checked++;
        if (pending_angles.size() == 0) begin
            $display("%0t: unexpected result pitch %0d yaw %0d", $time, got.pitch_deg,
                     got.yaw_deg);
            errors++;
            return;
        end
        want = pending_angles.pop_front();
        if (got.pitch_deg !== want.pitch_deg) begin
            $display("%0t: pitch mismatch expected %0d actual %0d", $time, want.pitch_deg,
                     got.pitch_deg);
            errors++;
        end
        if (got.yaw_deg !== want.yaw_deg) begin
            $display("%0t: yaw mismatch expected %0d actual %0d", $time, want.yaw_deg,
                     got.yaw_deg);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int RANDOM_WORDS = 1600;
    localparam int STALL_LIMIT  = 2000;   // far above the pipeline latency
    localparam int DRAIN_CYCLES = 100;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    dtpy_pkg::t_in_word  i_in;
    logic                o_strobe;
    dtpy_pkg::t_out_word o_out;

    angle_scoreboard sb;
    int              words_taken;
    int              idle_cycles;

    direction_to_pitch_yaw dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sample both handshakes at the rising edge; inputs only move at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_word(i_in);
            words_taken++;
        end
        if (i_rst_n && o_strobe) sb.check_result(o_out);
    end

    // watchdog: count cycles where no word moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress, %0d results still due", $time,
                         sb.pending_angles.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input dtpy_pkg::t_in_word w, input int gap);
        int n;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_in  = w;
        n     = words_taken;
        do @(negedge i_clk); while (words_taken == n);
    endtask

    // source and destination from explicit values
    function automatic dtpy_pkg::t_in_word make_pair(int sx, int sy, int sz,
                                                     int ex, int ey, int ez);
        dtpy_pkg::t_in_word w;
        w.src_x = sx; w.src_y = sy; w.src_z = sz;
        w.dst_x = ex; w.dst_y = ey; w.dst_z = ez;
        return w;
    endfunction

    // random pair: full range, small offsets, straight up/down, or x/y differences randomly zeroed
    function automatic dtpy_pkg::t_in_word random_pair();
        dtpy_pkg::t_in_word w;
        int                 kind;
        int                 sh;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(0, 9);
        sh   = $urandom_range(0, 30);
        if (kind >= 4 && kind <= 7) begin
            // short vectors exercise the upward scaling
            w.dst_x = w.src_x + (int'($urandom) >>> sh);
            w.dst_y = w.src_y + (int'($urandom) >>> sh);
            w.dst_z = w.src_z + (int'($urandom) >>> sh);
        end else if (kind == 8) begin
            w.dst_x = w.src_x;
            w.dst_y = w.src_y;
            if ($urandom_range(0, 3) == 0) w.dst_z = w.src_z;
        end else if (kind == 9) begin
            // randomly zero the x and/or y difference
            w.dst_x = ($urandom_range(0, 1)) ? w.src_x : w.dst_x;
            w.dst_y = ($urandom_range(0, 1)) ? w.src_y : w.dst_y;
        end
        return w;
    endfunction

    initial begin
        dtpy_pkg::t_in_word directed[$];
        int                 lo, hi;
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
        sb          = new();
        words_taken = 0;
        idle_cycles = 0;
        start       = 1'b0;
        i_in        = '0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // zero vector, straight up, straight down
        directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(5, 7, 0, 5, 7, 1));
        directed.push_back(make_pair(5, 7, 0, 5, 7, -1));
        directed.push_back(make_pair(0, 0, lo, 0, 0, hi));
        directed.push_back(make_pair(0, 0, hi, 0, 0, lo));
        // largest differences, on every axis or on x and y only
        directed.push_back(make_pair(lo, lo, lo, hi, hi, hi));
        directed.push_back(make_pair(hi, hi, hi, lo, lo, lo));
        directed.push_back(make_pair(lo, hi, lo, hi, lo, hi));
        directed.push_back(make_pair(hi, lo, 0, lo, hi, 0));
        // axis, near-axis and diagonal directions; negative x with y zero turns by +pi
        directed.push_back(make_pair(0, 0, 0, 1, 0, 0));
        directed.push_back(make_pair(0, 0, 0, -1, 0, 0));
        directed.push_back(make_pair(0, 0, 0, 0, 1, 0));
        directed.push_back(make_pair(0, 0, 0, 0, -1, 0));
        directed.push_back(make_pair(0, 0, 0, -65536, -1, 0));
        directed.push_back(make_pair(0, 0, 0, -65536, 1, 0));
        directed.push_back(make_pair(0, 0, 0, 65536, -1, 0));
        directed.push_back(make_pair(0, 0, 0, 1, 1, 1));
        directed.push_back(make_pair(0, 0, 0, -1, -1, -1));
        directed.push_back(make_pair(0, 0, 0, 1, 0, hi));
        directed.push_back(make_pair(0, 0, hi, 1, 0, lo));
        directed.push_back(make_pair(-1, -1, -1, -1, -1, -1));
        foreach (directed[i]) send_word(directed[i], $urandom_range(0, 3));

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // halfway: hold off until the pipeline has drained
            if (i == RANDOM_WORDS / 2) begin
                start = 1'b0;
                while (sb.pending_angles.size() != 0) @(negedge i_clk);
            end
            // bursts with no gaps between some stretches of random gaps
            send_word(random_pair(), ((i / 100) % 3 == 1) ? 0 : $urandom_range(0, 3));
        end
        start = 1'b0;

        while (sb.pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d point pairs (directed extremes, vertical and random vectors)",
                 words_taken);
        $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_angles.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/dtpy_pkg.sv
rtl/core/dtpy_cordic.sv
rtl/core/dtpy_to_deg.sv
rtl/core/direction_to_pitch_yaw.sv
rtl/core/dtpy_checker.sv
dv/tb.sv
